[hw/rtl/refcounted_handle_allocator_core_defines.svh]
// Assertion macros used by the checker module of the handle allocator.
`ifndef REFCOUNTED_HANDLE_ALLOCATOR_CORE_DEFINES_SVH
`define REFCOUNTED_HANDLE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RHAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("handle allocator check failed");

// Next-cycle implication, checked outside reset.
`define RHAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("handle allocator check failed");

`endif

[hw/rtl/rhal_pkg.sv]
// Types and codes shared by the handle allocator modules.
package rhal_pkg;

  localparam logic [1:0] CMD_NEW    = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_DROP   = 2'd2;
  localparam logic [1:0] CMD_LOOKUP = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_LIVE  = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  localparam logic [7:0] MAX_TYPE_RESET = 8'd8;
  localparam int unsigned REC_BITS = 40;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  handle;
    logic [7:0]  type_code;
    logic [31:0] element_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  result_handle;
    logic [15:0] ref_count;
    logic        freed;
    logic        live;
    logic [7:0]  record_type;
    logic [31:0] record_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

[hw/rtl/rhal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rhal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/rhal_ctrl.sv]
// Controller of the handle allocator: command sequencing and output valid.
module rhal_ctrl
  import rhal_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   capture, commit;

  assign capture = (state_q == S_IDLE) && in_valid_i;
  // The execute step finishes only once the output register is free or is being emptied.
  assign commit  = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (capture) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = capture;
  assign cmd_o.commit  = commit;

endmodule

[hw/rtl/rhal_datapath.sv]
// Datapath of the handle allocator: tables, free stack, counters and result register.
module rhal_datapath
  import rhal_pkg::*;
#(
  parameter int unsigned NUM_HANDLES    = 256,
  parameter int unsigned REF_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  input  in_item_t    in_data_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  output out_item_t   out_data_o
);

  localparam int unsigned HW  = $clog2(NUM_HANDLES);
  localparam int unsigned CW  = HW + 1;
  localparam int unsigned RCB = REF_COUNT_BITS;

  function automatic logic [HW-1:0] to_index(input logic [7:0] h);
    logic [HW+7:0] ext;
    ext = {{HW{1'b0}}, h};
    return ext[HW-1:0];
  endfunction

  function automatic logic [7:0] to_handle(input logic [HW-1:0] id);
    logic [HW+7:0] ext;
    ext = {8'b0, id};
    return ext[7:0];
  endfunction

  function automatic logic [15:0] to_count16(input logic [RCB-1:0] rc);
    logic [RCB+15:0] ext;
    ext = {16'b0, rc};
    return ext[15:0];
  endfunction

  in_item_t         in_q;
  out_item_t        out_q, out_d;
  logic [7:0]       max_type_q;
  logic [CW-1:0]    fresh_q, fresh_d;
  logic [CW-1:0]    depth_q, depth_d;
  logic [CW-1:0]    depth_m1;

  logic [HW-1:0]    q_idx;
  logic [RCB-1:0]   rc_rdata, rc_wdata, rc_dec;
  logic [REC_BITS-1:0] rec_rdata;
  logic [HW-1:0]    fs_rdata;
  logic             rc_we, rec_we, fs_we;
  logic [HW-1:0]    rc_waddr;
  logic             in_range, live_hit;

  assign q_idx    = to_index(in_q.handle);
  assign depth_m1 = depth_q - CW'(1);
  assign rc_dec   = rc_rdata - RCB'(1);
  assign in_range = (32'(in_q.handle) < NUM_HANDLES);
  // Entries at or above the fresh counter were never granted and read as free.
  assign live_hit = in_range && ({1'b0, q_idx} < fresh_q) && (rc_rdata != '0);

  rhal_ram #(.WIDTH(RCB), .DEPTH(NUM_HANDLES)) u_rc_ram (
    .clk_i   (clk_i),
    .we_i    (rc_we),
    .waddr_i (rc_waddr),
    .wdata_i (rc_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (to_index(in_data_i.handle)),
    .rdata_o (rc_rdata)
  );

  rhal_ram #(.WIDTH(REC_BITS), .DEPTH(NUM_HANDLES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rc_waddr),
    .wdata_i ({in_q.type_code, in_q.element_count}),
    .re_i    (cmd_i.capture),
    .raddr_i (to_index(in_data_i.handle)),
    .rdata_o (rec_rdata)
  );

  rhal_ram #(.WIDTH(HW), .DEPTH(NUM_HANDLES)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (depth_q[HW-1:0]),
    .wdata_i (q_idx),
    .re_i    (cmd_i.capture),
    .raddr_i (depth_m1[HW-1:0]),
    .rdata_o (fs_rdata)
  );

  always_comb begin
    logic          rc_sel, rec_sel, fs_sel;
    logic [HW-1:0] id;
    out_d    = '0;
    fresh_d  = fresh_q;
    depth_d  = depth_q;
    rc_sel   = 1'b0;
    rec_sel  = 1'b0;
    fs_sel   = 1'b0;
    rc_waddr = q_idx;
    rc_wdata = '0;
    id       = q_idx;
    if (in_q.command == CMD_NEW) begin
      if (in_q.type_code == 8'd0 || in_q.type_code > max_type_q) begin
        out_d.status = ST_BAD_TYPE;
      end else if (depth_q != '0 || fresh_q < CW'(NUM_HANDLES)) begin
        // Recently freed handles are reused first.
        if (depth_q != '0) begin
          id      = fs_rdata;
          depth_d = depth_m1;
        end else begin
          id      = fresh_q[HW-1:0];
          fresh_d = fresh_q + CW'(1);
        end
        rc_sel               = 1'b1;
        rec_sel              = 1'b1;
        rc_waddr             = id;
        rc_wdata             = RCB'(1);
        out_d.status         = ST_OK;
        out_d.result_handle  = to_handle(id);
        out_d.ref_count      = 16'd1;
        out_d.live           = 1'b1;
        out_d.record_type    = in_q.type_code;
        out_d.record_count   = in_q.element_count;
      end else begin
        out_d.status = ST_FULL;
      end
    end else if (!live_hit) begin
      out_d.status        = ST_NOT_LIVE;
      out_d.result_handle = in_q.handle;
    end else begin
      out_d.status        = ST_OK;
      out_d.result_handle = to_handle(q_idx);
      out_d.ref_count     = to_count16(rc_rdata);
      out_d.live          = 1'b1;
      out_d.record_type   = rec_rdata[REC_BITS-1 -: 8];
      out_d.record_count  = rec_rdata[31:0];
      case (in_q.command)
        CMD_ADD: begin
          if (rc_rdata == '1) begin
            out_d.status = ST_SATURATED;
          end else begin
            rc_sel          = 1'b1;
            rc_wdata        = rc_rdata + RCB'(1);
            out_d.ref_count = to_count16(rc_rdata + RCB'(1));
          end
        end
        CMD_DROP: begin
          rc_sel          = 1'b1;
          rc_wdata        = rc_dec;
          out_d.ref_count = to_count16(rc_dec);
          if (rc_dec == '0) begin
            fs_sel      = 1'b1;
            depth_d     = depth_q + CW'(1);
            out_d.freed = 1'b1;
            out_d.live  = 1'b0;
          end
        end
        CMD_LOOKUP: begin
        end
        default: begin
        end
      endcase
    end
    rc_we  = cmd_i.commit && rc_sel;
    rec_we = cmd_i.commit && rec_sel;
    fs_we  = cmd_i.commit && fs_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_type_q <= MAX_TYPE_RESET;
      fresh_q    <= '0;
      depth_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        max_type_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        fresh_q <= fresh_d;
        depth_q <= depth_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

[hw/rtl/refcounted_handle_allocator_core.sv]
// Top level of the reference-counted handle allocator.
//
// Input channel (in_valid_i, in_stall_o, in_data_i) carries one command per
// transfer: new, add reference, drop reference or lookup. Each command gives
// exactly one result on the output channel (out_valid_o, out_stall_i,
// out_data_o), in command order.
// A command runs as a read step and an execute step: in the transfer cycle the
// reference count table, the record table and the top of the free stack are read;
// in the execute step the result is formed, the tables and stack are written and
// the result is registered. The block takes no new command until the execute
// step of the last one has finished; the single read-modify-write of the tables
// per command is the reason.
// While the receiver stalls, the result register holds; one more command may be
// taken, and its execute step waits until the result register frees.
// The configuration channel writes max_type_code at any cfg_valid_i cycle; it
// is always ready and should be written only while the block is idle.
// Reset clears the fresh handle counter and the free stack depth and sets
// max_type_code to 8; handles never granted read as free, so no clearing pass
// runs and commands are taken in the first cycle after reset.
module refcounted_handle_allocator_core
  import rhal_pkg::*;
#(
  parameter int unsigned NUM_HANDLES    = 256,
  parameter int unsigned REF_COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  ctrl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  rhal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rhal_datapath #(
    .NUM_HANDLES    (NUM_HANDLES),
    .REF_COUNT_BITS (REF_COUNT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

[hw/rtl/rhal_checker.sv]
// Port-level assertions for the handle allocator and their binding.
`include "refcounted_handle_allocator_core_defines.svh"

module rhal_checker
  import rhal_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result stays in place.
  `RHAL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // After an input transfer the block is busy executing that command.
  `RHAL_ASSERT_NXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result appears only at the end of an execute step.
  `RHAL_ASSERT_IMP(a_result_after_exec, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // A released handle is reported with no live record and a zero count.
  `RHAL_ASSERT_IMP(a_freed_not_live, clk_i, rst_ni, out_valid_o && out_data_o.freed, !out_data_o.live && out_data_o.ref_count == 16'd0)

endmodule

bind refcounted_handle_allocator_core rhal_checker u_checker (.*);

[dv/refcounted_handle_allocator_core_tb.sv]
// Self-checking testbench for the reference-counted handle allocator core.
module refcounted_handle_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rhal_pkg::*;

  localparam int unsigned NUM_H = 256;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    in_item_t  cmd;
    logic      fixed;
    out_item_t want;
  } step_row_t;

  localparam int N_ROWS = 23;
  localparam step_row_t DIRECTED [N_ROWS] = '{
    '{'{CMD_LOOKUP, 8'h00, 8'h00, 32'h0}, 1'b1,
      '{ST_NOT_LIVE, 8'h00, 16'h0, 1'b0, 1'b0, 8'h00, 32'h0}},
    '{'{CMD_ADD, 8'hFF, 8'h00, 32'h0}, 1'b1,
      '{ST_NOT_LIVE, 8'hFF, 16'h0, 1'b0, 1'b0, 8'h00, 32'h0}},
    '{'{CMD_DROP, 8'hAA, 8'h55, 32'h1234_5678}, 1'b1,
      '{ST_NOT_LIVE, 8'hAA, 16'h0, 1'b0, 1'b0, 8'h00, 32'h0}},
    '{'{CMD_NEW, 8'h00, 8'h00, 32'hFFFF_FFFF}, 1'b1,
      '{ST_BAD_TYPE, 8'h00, 16'h0, 1'b0, 1'b0, 8'h00, 32'h0}},
    '{'{CMD_NEW, 8'h00, 8'h09, 32'h0000_0001}, 1'b1,
      '{ST_BAD_TYPE, 8'h00, 16'h0, 1'b0, 1'b0, 8'h00, 32'h0}},
    '{'{CMD_NEW, 8'h55, 8'hFF, 32'hA5A5_A5A5}, 1'b1,
      '{ST_BAD_TYPE, 8'h00, 16'h0, 1'b0, 1'b0, 8'h00, 32'h0}},
    '{'{CMD_NEW, 8'h00, 8'h01, 32'h0}, 1'b1,
      '{ST_OK, 8'h00, 16'h1, 1'b0, 1'b1, 8'h01, 32'h0}},
    '{'{CMD_NEW, 8'h00, 8'h08, 32'hFFFF_FFFF}, 1'b1,
      '{ST_OK, 8'h01, 16'h1, 1'b0, 1'b1, 8'h08, 32'hFFFF_FFFF}},
    '{'{CMD_NEW, 8'hFF, 8'h05, 32'h5555_AAAA}, 1'b0, '0},
    '{'{CMD_ADD, 8'h00, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_LOOKUP, 8'h00, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_DROP, 8'h00, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_DROP, 8'h00, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_LOOKUP, 8'h00, 8'h00, 32'h0}, 1'b1,
      '{ST_NOT_LIVE, 8'h00, 16'h0, 1'b0, 1'b0, 8'h00, 32'h0}},
    '{'{CMD_DROP, 8'h01, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_NEW, 8'h00, 8'h03, 32'h0000_0007}, 1'b0, '0},
    '{'{CMD_NEW, 8'h00, 8'h02, 32'h0000_0001}, 1'b0, '0},
    '{'{CMD_NEW, 8'h00, 8'h04, 32'h8000_0000}, 1'b0, '0},
    '{'{CMD_ADD, 8'h03, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_LOOKUP, 8'h03, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_DROP, 8'h02, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_LOOKUP, 8'h02, 8'h00, 32'h0}, 1'b1,
      '{ST_NOT_LIVE, 8'h02, 16'h0, 1'b0, 1'b0, 8'h00, 32'h0}},
    '{'{CMD_LOOKUP, 8'h80, 8'h00, 32'h0}, 1'b1,
      '{ST_NOT_LIVE, 8'h80, 16'h0, 1'b0, 1'b0, 8'h00, 32'h0}}
  };

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  // Shadow copy of the handle table.
  logic [15:0] ref_tab [NUM_H];
  bit          live_tab [NUM_H];
  logic [7:0]  type_tab [NUM_H];
  logic [31:0] count_tab [NUM_H];
  logic [7:0]  free_lifo [$];
  int unsigned next_fresh;
  logic [7:0]  max_type;

  out_item_t   pending_results [$];
  int unsigned mismatches;
  bit          full_seen;

  int unsigned burst_left;
  int unsigned tx_gap_max;
  bit          rx_quiet;
  bit          hold_off_req;

  refcounted_handle_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Applies one command to the shadow table and returns the result it gives.
  function automatic out_item_t table_outcome(in_item_t c);
    out_item_t  r;
    logic [7:0] h;
    r = '0;
    if (c.command == CMD_NEW) begin
      if (c.type_code == 8'd0 || c.type_code > max_type) begin
        r.status = ST_BAD_TYPE;
      end else if (free_lifo.size() == 0 && next_fresh >= NUM_H) begin
        r.status = ST_FULL;
      end else begin
        if (free_lifo.size() > 0) begin
          h = free_lifo.pop_back();
        end else begin
          h = next_fresh[7:0];
          next_fresh++;
        end
        live_tab[h] = 1'b1;
        ref_tab[h] = 16'd1;
        type_tab[h] = c.type_code;
        count_tab[h] = c.element_count;
        r.status = ST_OK;
        r.result_handle = h;
        r.ref_count = 16'd1;
        r.live = 1'b1;
        r.record_type = c.type_code;
        r.record_count = c.element_count;
      end
    end else if (!live_tab[c.handle]) begin
      r.status = ST_NOT_LIVE;
      r.result_handle = c.handle;
    end else begin
      h = c.handle;
      r.status = ST_OK;
      r.result_handle = h;
      r.live = 1'b1;
      r.record_type = type_tab[h];
      r.record_count = count_tab[h];
      if (c.command == CMD_ADD) begin
        if (ref_tab[h] == 16'hFFFF) r.status = ST_SATURATED;
        else ref_tab[h]++;
      end else if (c.command == CMD_DROP) begin
        ref_tab[h]--;
        if (ref_tab[h] == 16'd0) begin
          live_tab[h] = 1'b0;
          free_lifo = {free_lifo, h};
          r.freed = 1'b1;
          r.live = 1'b0;
        end
      end
      r.ref_count = ref_tab[h];
    end
    return r;
  endfunction

  // Mostly a live handle, so that add and drop get past the liveness check.
  function automatic logic [7:0] pick_handle();
    int unsigned start;
    start = $urandom_range(0, NUM_H - 1);
    if ($urandom_range(0, 99) < 85) begin
      for (int i = 0; i < NUM_H; i++) begin
        if (live_tab[(start + i) % NUM_H]) return 8'((start + i) % NUM_H);
      end
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t random_command(int unsigned w_new, int unsigned w_add,
                                              int unsigned w_drop);
    in_item_t    c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < w_new) c.command = CMD_NEW;
    else if (roll < w_new + w_add) c.command = CMD_ADD;
    else if (roll < w_new + w_add + w_drop) c.command = CMD_DROP;
    else c.command = CMD_LOOKUP;
    c.handle = pick_handle();
    roll = $urandom_range(0, 99);
    if (roll < 80) c.type_code = 8'($urandom_range(1, max_type));
    else if (roll < 88) c.type_code = 8'd0;
    else c.type_code = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 9);
    if (roll == 0) c.element_count = '0;
    else if (roll == 1) c.element_count = '1;
    else c.element_count = $urandom();
    return c;
  endfunction

  // Offers one command and returns once it has been transferred.
  task automatic issue_command(output out_item_t seen, input in_item_t c,
                               input bit fixed = 1'b0, input out_item_t typed = '0);
    if (tx_gap_max > 0 && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, tx_gap_max)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    in_data_i <= c;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    seen = table_outcome(c);
    if (seen.status == ST_FULL) full_seen = 1'b1;
    pending_results = {pending_results, (fixed ? typed : seen)};
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_max_type(input logic [7:0] value);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    max_type = value;
  endtask

  task automatic run_random(int unsigned n, int unsigned w_new, int unsigned w_add,
                            int unsigned w_drop, int hold_at);
    out_item_t res;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      issue_command(res, random_command(w_new, w_add, w_drop));
    end
  endtask

  function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    return 1;
  endfunction

  // Result checker.
  initial begin : result_check
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, out_data_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          mismatches += field_bad("status", 32'(want.status), 32'(out_data_o.status))
            + field_bad("result_handle", 32'(want.result_handle),
                        32'(out_data_o.result_handle))
            + field_bad("ref_count", 32'(want.ref_count), 32'(out_data_o.ref_count))
            + field_bad("freed", 32'(want.freed), 32'(out_data_o.freed))
            + field_bad("live", 32'(want.live), 32'(out_data_o.live))
            + field_bad("record_type", 32'(want.record_type), 32'(out_data_o.record_type))
            + field_bad("record_count", want.record_count, out_data_o.record_count);
        end
      end
    end
  end

  // Receiver: a stall pattern drawn anew from four modes, plus one long hold-off.
  initial begin : receiver
    int unsigned hold;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    hold = 0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LONG_HOLD;
        out_stall_i <= 1'b1;
      end else if (rx_quiet || mode == 0) begin
        out_stall_i <= 1'b0;
      end else if (mode == 1) begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end else if (mode == 2) begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end else begin
        out_stall_i <= ((tick % 7) < 3);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("[refcounted_handle_allocator_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    out_item_t   res;
    logic [7:0]  sat_handle;
    for (int i = 0; i < NUM_H; i++) begin
      ref_tab[i] = '0;
      live_tab[i] = 1'b0;
      type_tab[i] = '0;
      count_tab[i] = '0;
    end
    next_fresh = 0;
    max_type = MAX_TYPE_RESET;
    mismatches = 0;
    full_seen = 1'b0;
    burst_left = 0;
    tx_gap_max = 6;
    rx_quiet = 1'b0;
    hold_off_req = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run with the reset value of the type limit.
    for (int i = 0; i < N_ROWS; i++)
      issue_command(res, DIRECTED[i].cmd, DIRECTED[i].fixed, DIRECTED[i].want);

    // Make one handle without gaps and with no receiver stall, then work it with gaps.
    write_max_type(8'd1);
    tx_gap_max = 0;
    rx_quiet = 1'b1;
    issue_command(res, '{CMD_NEW, 8'h00, 8'd2, 32'h0F0F_F0F0});
    issue_command(res, '{CMD_NEW, 8'h00, 8'd1, 32'h0F0F_F0F0});
    sat_handle = res.result_handle;
    tx_gap_max = 6;
    rx_quiet = 1'b0;
    issue_command(res, '{CMD_ADD, sat_handle, 8'h00, 32'h0});
    issue_command(res, '{CMD_DROP, sat_handle, 8'h00, 32'h0});
    issue_command(res, '{CMD_ADD, sat_handle, 8'h00, 32'h0});
    issue_command(res, '{CMD_ADD, sat_handle, 8'h00, 32'h0});
    issue_command(res, '{CMD_LOOKUP, sat_handle, 8'h00, 32'h0});

    // Fill the table until it reports full; the long receiver hold-off falls here.
    write_max_type(8'd255);
    tx_gap_max = 10;
    run_random(700, 60, 10, 10, 150);
    while (!full_seen) issue_command(res, '{CMD_NEW, 8'h00, 8'd1, $urandom()});

    write_max_type(8'($urandom_range(2, 254)));
    tx_gap_max = 4;
    run_random(500, 15, 10, 55, -1);

    write_max_type(8'($urandom_range(1, 255)));
    tx_gap_max = 8;
    run_random(450, 30, 20, 30, -1);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[refcounted_handle_allocator_core] OK");
    else
      $display("[refcounted_handle_allocator_core] ERROR");
    $finish;
  end

endmodule
